/* hw/rtl/scap_pkg.sv */
package scap_pkg;

    // History store geometry.
    localparam int HIST_DEPTH = 8192;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CNT_W      = HIST_AW + 1;

    // Display points.
    localparam int MAX_POINTS = 64;
    localparam int PTS_W      = 7;
    localparam int PNUM_W     = 6;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Input word kinds.
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_GRAPH = 2'd1;
    localparam logic [1:0] KIND_PEAK  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Result kinds.
    localparam logic [1:0] RES_POINT    = 2'd0;
    localparam logic [1:0] RES_PEAK     = 2'd1;
    localparam logic [1:0] RES_NOTREADY = 2'd2;

    // Trigger modes.
    localparam logic [1:0] SYNC_RISE = 2'd1;
    localparam logic [1:0] SYNC_FALL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK   = 3'd4;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  graph_points;
        logic [13:0] window_samples;
        logic [13:0] offset_samples;
        logic [1:0]  sync_mode;
        logic [12:0] peak_samples;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [SAMPLE_W-1:0] value;
        logic [PNUM_W-1:0]          point;
        logic                       last;
    } result_t;

endpackage

/* hw/rtl/scap_front.sv */
module scap_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       kind,
    input  logic signed [15:0]               sample_value,
    input  logic                             cfg_write,
    input  logic [scap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scap_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output scap_pkg::cmd_t                   cmd,
    output scap_pkg::cfg_t                   cfg
);
    import scap_pkg::*;

    cmd_t       q_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    cfg_t       cfg_reg;
    logic       do_enq;
    logic       do_deq;

    // A word of an unused kind is accepted and dropped here.
    assign full      = (count_reg == 3'd4);
    assign do_enq    = push && !full && (kind != KIND_NONE);
    assign cmd_valid = (count_reg != 3'd0);
    assign do_deq    = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];
    assign cfg       = cfg_reg;

    // Command queue storage.
    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            q_reg[wr_ptr_reg] <= '{kind: kind, sample: sample_value};
        end
    end

    // Queue pointers and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            cfg_reg    <= '{graph_points: 7'd10, window_samples: 14'd4800,
                            offset_samples: 14'd0, sync_mode: 2'd0,
                            peak_samples: 13'd7200};
        end
        else
        begin
            if (do_enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (do_enq && !do_deq)
            begin
                count_reg <= count_reg + 3'd1;
            end
            else if (!do_enq && do_deq)
            begin
                count_reg <= count_reg - 3'd1;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_POINTS: cfg_reg.graph_points   <= cfg_data[6:0];
                    CFG_WINDOW: cfg_reg.window_samples <= cfg_data;
                    CFG_OFFSET: cfg_reg.offset_samples <= cfg_data;
                    CFG_SYNC:   cfg_reg.sync_mode      <= cfg_data[1:0];
                    CFG_PEAK:   cfg_reg.peak_samples   <= cfg_data[12:0];
                    default:    ;
                endcase
            end
        end
    end

endmodule

/* hw/rtl/scap_outq.sv */
module scap_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    output logic              full,
    input  scap_pkg::result_t wr_data,
    output logic              empty,
    input  logic              pop,
    output scap_pkg::result_t rd_data
);
    import scap_pkg::*;

    result_t    q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = q_reg[rd_ptr_reg];

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!do_wr && do_rd)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/scap_engine.sv */
module scap_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  scap_pkg::cfg_t    cfg,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  scap_pkg::cmd_t    cmd,
    input  logic              res_full,
    output logic              res_push,
    output scap_pkg::result_t res
);
    import scap_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_TRIG_RD, S_TRIG_EVAL, S_OFFSET, S_PT_RD, S_PT_EMIT,
        S_PK_SCAN, S_PK_EMIT, S_NR_EMIT
    } state_t;

    typedef enum logic [1:0] {PH_ENTER1, PH_LOOP1, PH_ENTER2, PH_LOOP2} phase_t;

    // History memory.
    logic [SAMPLE_W-1:0] mem [HIST_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [HIST_AW-1:0]  mem_raddr;

    state_t              state_reg,  state_next;
    phase_t              phase_reg,  phase_next;
    logic [HIST_AW-1:0]  wp_reg,     wp_next;
    logic [CNT_W-1:0]    fill_reg,   fill_next;
    logic [CNT_W-1:0]    start_reg,  start_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic [PTS_W-1:0]    points_reg, points_next;
    logic [CNT_W-1:0]    divq_reg,   divq_next;
    logic [7:0]          divrem_reg, divrem_next;
    logic [3:0]          divcnt_reg, divcnt_next;
    logic [CNT_W-1:0]    pick_reg,   pick_next;
    logic [7:0]          prem_reg,   prem_next;
    logic [PTS_W-1:0]    pnum_reg,   pnum_next;
    logic [14:0]         best_reg,   best_next;
    logic [12:0]         pkcnt_reg,  pkcnt_next;
    logic                rdv_reg,    rdv_next;

    logic [HIST_AW-1:0]  base_addr;
    logic [PTS_W-1:0]    pts_eff;
    logic [CNT_W-1:0]    win_eff;
    logic [7:0]          rem_sh;
    logic                qbit;
    logic signed [SAMPLE_W-1:0] d;
    logic                d_neg;
    logic                d_pos;
    logic                rising;
    logic                e1, p1, e2, p2;
    logic                trig_done;
    logic                pt_last;
    logic [7:0]          rsum;
    logic [CNT_W-1:0]    pt_pos;
    logic [SAMPLE_W-1:0] d_negated;
    logic [14:0]         mag;

    // Oldest held sample sits at the write pointer minus the fill count.
    assign base_addr = wp_reg - fill_reg[HIST_AW-1:0];

    // Effective point count and window length.
    always_comb
    begin
        if (cfg.graph_points == '0)
        begin
            pts_eff = PTS_W'(1);
        end
        else if (cfg.graph_points > PTS_W'(MAX_POINTS))
        begin
            pts_eff = PTS_W'(MAX_POINTS);
        end
        else
        begin
            pts_eff = cfg.graph_points;
        end
        if (cfg.window_samples == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (cfg.window_samples > CNT_W'(HIST_DEPTH))
        begin
            win_eff = CNT_W'(HIST_DEPTH);
        end
        else
        begin
            win_eff = cfg.window_samples;
        end
    end

    // Sample classification for the trigger search and the peak scan.
    assign d         = rd_data_reg;
    assign d_neg     = d[SAMPLE_W-1];
    assign d_pos     = !d[SAMPLE_W-1] && (d != '0);
    assign rising    = (cfg.sync_mode == SYNC_RISE);
    assign e1        = rising ? d_neg : d_pos;
    assign p1        = rising ? !d_pos : d_pos;
    assign e2        = rising ? d_pos : d_neg;
    assign p2        = rising ? d_pos : !d_pos;
    assign d_negated = ~rd_data_reg + 16'd1;
    assign mag       = !d_neg ? rd_data_reg[14:0]
                     : (d_negated[15] ? 15'h7fff : d_negated[14:0]);

    // Restoring divider step and graph point arithmetic.
    assign rem_sh  = {divrem_reg[6:0], divq_reg[CNT_W-1]};
    assign qbit    = (rem_sh >= {1'b0, points_reg});
    assign pt_last = ((pnum_reg + PTS_W'(1)) == points_reg);
    assign rsum    = prem_reg + divrem_reg;
    assign pt_pos  = start_reg + pick_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        start_next  = start_reg;
        idx_next    = idx_reg;
        points_next = points_reg;
        divq_next   = divq_reg;
        divrem_next = divrem_reg;
        divcnt_next = divcnt_reg;
        pick_next   = pick_reg;
        prem_next   = prem_reg;
        pnum_next   = pnum_reg;
        best_next   = best_reg;
        pkcnt_next  = pkcnt_reg;
        rdv_next    = rdv_reg;
        cmd_ready   = 1'b0;
        res_push    = 1'b0;
        res         = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = base_addr;
        trig_done   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_ready = 1'b1;
                    priority if (cmd.kind == KIND_PUSH)
                    begin
                        mem_we  = 1'b1;
                        wp_next = wp_reg + HIST_AW'(1);
                        if (fill_reg != CNT_W'(HIST_DEPTH))
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else if (cmd.kind == KIND_GRAPH)
                    begin
                        points_next = pts_eff;
                        if (fill_reg < win_eff)
                        begin
                            state_next = S_NR_EMIT;
                        end
                        else
                        begin
                            start_next  = fill_reg - win_eff;
                            idx_next    = fill_reg - win_eff;
                            divq_next   = win_eff;
                            divrem_next = '0;
                            divcnt_next = '0;
                            state_next  = S_DIV;
                        end
                    end
                    else
                    begin
                        best_next  = '0;
                        pkcnt_next = '0;
                        rdv_next   = 1'b0;
                        if (fill_reg > {1'b0, cfg.peak_samples})
                        begin
                            state_next = S_PK_SCAN;
                        end
                        else
                        begin
                            state_next = S_PK_EMIT;
                        end
                    end
                end
            end

            // Window over point count, one quotient bit a cycle.
            S_DIV:
            begin
                divrem_next = qbit ? (rem_sh - {1'b0, points_reg}) : rem_sh;
                divq_next   = {divq_reg[CNT_W-2:0], qbit};
                divcnt_next = divcnt_reg + 4'd1;
                if (divcnt_reg == 4'(CNT_W - 1))
                begin
                    if (cfg.sync_mode == SYNC_RISE || cfg.sync_mode == SYNC_FALL)
                    begin
                        phase_next = PH_ENTER1;
                        state_next = S_TRIG_RD;
                    end
                    else
                    begin
                        state_next = S_OFFSET;
                    end
                end
            end

            S_TRIG_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = base_addr + idx_reg[HIST_AW-1:0];
                state_next = S_TRIG_EVAL;
            end

            // Walk back past the first run, then past the opposite run.
            S_TRIG_EVAL:
            begin
                unique case (phase_reg)
                    PH_ENTER1:
                    begin
                        phase_next = e1 ? PH_LOOP1 : PH_ENTER2;
                    end
                    PH_LOOP1:
                    begin
                        if (idx_reg != '0 && p1)
                        begin
                            idx_next   = idx_reg - CNT_W'(1);
                            state_next = S_TRIG_RD;
                        end
                        else
                        begin
                            phase_next = PH_ENTER2;
                        end
                    end
                    PH_ENTER2:
                    begin
                        if (e2)
                        begin
                            phase_next = PH_LOOP2;
                        end
                        else
                        begin
                            trig_done = 1'b1;
                        end
                    end
                    PH_LOOP2:
                    begin
                        if (idx_reg != '0 && p2)
                        begin
                            idx_next   = idx_reg - CNT_W'(1);
                            state_next = S_TRIG_RD;
                        end
                        else
                        begin
                            trig_done = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (trig_done)
                begin
                    if (idx_reg != '0)
                    begin
                        start_next = idx_reg;
                    end
                    state_next = S_OFFSET;
                end
            end

            // Step back by the offset, clamped at the oldest sample.
            S_OFFSET:
            begin
                start_next = (start_reg > cfg.offset_samples)
                           ? start_reg - cfg.offset_samples : '0;
                pick_next  = '0;
                prem_next  = '0;
                pnum_next  = '0;
                state_next = S_PT_RD;
            end

            S_PT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = base_addr + pt_pos[HIST_AW-1:0];
                state_next = S_PT_EMIT;
            end

            // Emit one point, then advance the pick by window / points.
            S_PT_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    res      = '{kind: RES_POINT, value: rd_data_reg,
                                 point: pnum_reg[PNUM_W-1:0], last: pt_last};
                    if (pt_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pnum_next = pnum_reg + PTS_W'(1);
                        if (rsum >= {1'b0, points_reg})
                        begin
                            pick_next = pick_reg + divq_reg + CNT_W'(1);
                            prem_next = rsum - {1'b0, points_reg};
                        end
                        else
                        begin
                            pick_next = pick_reg + divq_reg;
                            prem_next = rsum;
                        end
                        state_next = S_PT_RD;
                    end
                end
            end

            // Read one sample a cycle, newest first, and keep the largest magnitude.
            S_PK_SCAN:
            begin
                if (pkcnt_reg != cfg.peak_samples)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = wp_reg - HIST_AW'(1) - pkcnt_reg;
                    pkcnt_next = pkcnt_reg + 13'd1;
                    rdv_next   = 1'b1;
                end
                else
                begin
                    rdv_next = 1'b0;
                end
                if (rdv_reg && (mag > best_reg))
                begin
                    best_next = mag;
                end
                if (pkcnt_reg == cfg.peak_samples && !rdv_reg)
                begin
                    state_next = S_PK_EMIT;
                end
            end

            S_PK_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res        = '{kind: RES_PEAK, value: {1'b0, best_reg},
                                   point: '0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            S_NR_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res        = '{kind: RES_NOTREADY, value: '0, point: '0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= cmd.sample;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Sequencer state and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_ENTER1;
            wp_reg    <= '0;
            fill_reg  <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        idx_reg    <= idx_next;
        points_reg <= points_next;
        divq_reg   <= divq_next;
        divrem_reg <= divrem_next;
        divcnt_reg <= divcnt_next;
        pick_reg   <= pick_next;
        prem_reg   <= prem_next;
        pnum_reg   <= pnum_next;
        best_reg   <= best_next;
        pkcnt_reg  <= pkcnt_next;
    end

endmodule

/* hw/rtl/scope_capture_trigger.sv */
// Oscilloscope capture with a zero-crossing trigger. Samples are pushed as
// words of kind push and land in an 8192-entry history at one per cycle while
// the sequencer is idle; the history has one write and one registered read
// port, and no clearing pass is needed after reset. A graph request runs the
// window / points divider, then the trigger search with one history read per
// sample visited plus its phase changes, then the offset step, and then one
// history read per emitted point. A peak request makes one history read per
// sample; when too few samples are held it skips the scan and answers zero.
// Requests are served one at a time, in order; a four-word input queue and a
// two-word result queue let either side stall without stopping the other.
module scope_capture_trigger (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       kind,
    input  logic signed [15:0]               sample_value,
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       result_kind,
    output logic signed [15:0]               out_value,
    output logic [5:0]                       point_number,
    output logic                             last,
    input  logic                             cfg_write,
    input  logic [scap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scap_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import scap_pkg::*;

    cmd_t    cmd;
    cfg_t    cfg;
    logic    cmd_valid;
    logic    cmd_ready;
    logic    res_full;
    logic    res_push;
    result_t res;
    result_t res_head;

    // Input side: queue words and hold configuration.
    scap_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .sample_value (sample_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .cfg          (cfg)
    );

    // History and request sequencer.
    scap_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // Result queue.
    scap_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .full    (res_full),
        .wr_data (res),
        .empty   (empty),
        .pop     (pop),
        .rd_data (res_head)
    );

    assign result_kind  = res_head.kind;
    assign out_value    = res_head.value;
    assign point_number = res_head.point;
    assign last         = res_head.last;

endmodule

/* hw/rtl/scap_checker.sv */
module scap_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic [1:0]         result_kind,
    input logic signed [15:0] out_value,
    input logic [5:0]         point_number,
    input logic               last
);
    import scap_pkg::*;

    // A peak or not-ready result is a single word.
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (result_kind == RES_PEAK || result_kind == RES_NOTREADY)
        |-> last && (point_number == '0))
        else $error("single-word result without last or with a point number");

    // A peak magnitude is never negative.
    a_peak_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (result_kind == RES_PEAK) |-> !out_value[15])
        else $error("negative peak magnitude");

    // A not-ready result carries a zero value.
    a_notready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (result_kind == RES_NOTREADY) |-> (out_value == '0))
        else $error("not-ready result with a value");

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_value) && $stable(result_kind))
        else $error("waiting result changed");

endmodule

bind scope_capture_trigger scap_checker u_scap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .out_value    (out_value),
    .point_number (point_number),
    .last         (last)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import scap_pkg::*;

    localparam int STALL_LIMIT = 80000;
    localparam int RANDOM_WORDS = 145;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [1:0] kind;
    logic signed [15:0] sample_value;
    logic empty;
    logic pop;
    logic [1:0] result_kind;
    logic signed [15:0] out_value;
    logic [5:0] point_number;
    logic res_last;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    scope_capture_trigger dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .sample_value(sample_value),
        .empty(empty),
        .pop(pop),
        .result_kind(result_kind),
        .out_value(out_value),
        .point_number(point_number),
        .last(res_last),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the capture state and its registers.
    logic signed [15:0] shadow_hist [HIST_DEPTH];
    int unsigned shadow_wp;
    int unsigned shadow_fill;
    logic [6:0] reg_points;
    logic [13:0] reg_window;
    logic [13:0] reg_offset;
    logic [1:0] reg_sync;
    logic [12:0] reg_peak;

    result_t pending_results[$];

    int mismatches;
    int results_seen;
    int pushes_done;
    int graphs_done;
    int peaks_done;
    int random_words;
    bit no_idle;
    bit long_hold_req;
    int rx_stall;

    typedef struct {
        bit is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [13:0] data;
        logic [1:0] wkind;
        logic signed [15:0] smp;
        bit typed;
        result_t want;
    } plan_row_t;

    plan_row_t plan[$];

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Sample number j counted from the oldest held sample.
    function automatic int held_sample(int unsigned j);
        return int'(shadow_hist[(shadow_wp + HIST_DEPTH - shadow_fill + j) % HIST_DEPTH]);
    endfunction

    function automatic void queue_result(logic [1:0] rk, logic signed [15:0] v,
                                         int unsigned pn, bit lst);
        result_t r;
        r.kind = rk;
        r.value = v;
        r.point = pn[PNUM_W-1:0];
        r.last = lst;
        pending_results = {pending_results, r};
    endfunction

    // Graph request: trigger search, offset clamp, then evenly spaced picks.
    function automatic void predict_graph();
        int unsigned pts;
        int unsigned win;
        int unsigned start;
        int unsigned idx;
        int unsigned pick;
        pts = reg_points;
        win = reg_window;
        if (pts == 0) pts = 1;
        if (pts > MAX_POINTS) pts = MAX_POINTS;
        if (win == 0) win = 1;
        if (win > HIST_DEPTH) win = HIST_DEPTH;
        if (shadow_fill < win) begin
            queue_result(RES_NOTREADY, 16'sd0, 0, 1'b1);
            return;
        end
        start = shadow_fill - win;
        idx = start;
        if (reg_sync == SYNC_RISE) begin
            if (held_sample(idx) < 0)
                while (idx != 0 && held_sample(idx) <= 0) idx--;
            if (held_sample(idx) > 0)
                while (idx != 0 && held_sample(idx) > 0) idx--;
            if (idx > 0) start = idx;
        end else if (reg_sync == SYNC_FALL) begin
            if (held_sample(idx) > 0)
                while (idx != 0 && held_sample(idx) > 0) idx--;
            if (held_sample(idx) < 0)
                while (idx != 0 && held_sample(idx) <= 0) idx--;
            if (idx > 0) start = idx;
        end
        start = (start > reg_offset) ? start - reg_offset : 0;
        for (int unsigned i = 0; i < pts; i++) begin
            pick = (i * win) / pts;
            queue_result(RES_POINT, 16'(held_sample(start + pick)), i, (i + 1 == pts));
        end
    endfunction

    // Peak request: largest saturated magnitude over the newest samples.
    function automatic void predict_peak();
        int best;
        int v;
        best = 0;
        if (shadow_fill > reg_peak) begin
            for (int unsigned c = 0; c < reg_peak; c++) begin
                v = held_sample(shadow_fill - 1 - c);
                if (v < 0) v = -v;
                if (v > 32767) v = 32767;
                if (v > best) best = v;
            end
        end
        queue_result(RES_PEAK, 16'(best), 0, 1'b1);
    endfunction

    function automatic void predict_word(logic [1:0] wk, logic signed [15:0] s, bit typed);
        if (wk == KIND_PUSH) begin
            shadow_hist[shadow_wp] = s;
            shadow_wp = (shadow_wp + 1) % HIST_DEPTH;
            if (shadow_fill < HIST_DEPTH) shadow_fill++;
            pushes_done++;
        end else if (wk == KIND_GRAPH) begin
            graphs_done++;
            if (!typed) predict_graph();
        end else if (wk == KIND_PEAK) begin
            peaks_done++;
            if (!typed) predict_peak();
        end
    endfunction

    function automatic logic signed [15:0] random_sample();
        if ($urandom_range(0, 1) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 40)) - 20);
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(logic [1:0] wk, logic signed [15:0] s, bit typed, result_t want);
        bit taken;
        push <= 1'b1;
        kind <= wk;
        sample_value <= s;
        do begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end while (!taken);
        if (typed) pending_results = {pending_results, want};
        predict_word(wk, s, typed);
    endtask

    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Wait until every expected word is back, then let queued pushes settle.
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_POINTS: reg_points = val[6:0];
            CFG_WINDOW: reg_window = val[13:0];
            CFG_OFFSET: reg_offset = val[13:0];
            CFG_SYNC: reg_sync = val[1:0];
            CFG_PEAK: reg_peak = val[12:0];
            default: ;
        endcase
    endtask

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = val[13:0];
        plan = {plan, r};
    endfunction

    function automatic void plan_word(logic [1:0] wk, logic signed [15:0] s,
                                      bit typed = 1'b0, logic [1:0] rk = RES_POINT,
                                      logic signed [15:0] v = 16'sd0);
        plan_row_t r;
        r = '{default: '0};
        r.wkind = wk;
        r.smp = s;
        r.typed = typed;
        r.want.kind = rk;
        r.want.value = v;
        r.want.point = '0;
        r.want.last = 1'b1;
        plan = {plan, r};
    endfunction

    // Compare each taken result word with the oldest expectation.
    always @(negedge clk) begin
        if (rst_n && pop && !empty) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: kind %0d value %0d point %0d last %0b",
                             result_kind, out_value, point_number, res_last);
            end else begin
                result_t w;
                w = pending_results[0];
                pending_results.delete(0);
                if (w.kind !== result_kind || w.value !== out_value ||
                    w.point !== point_number || w.last !== res_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 w.kind, w.value, w.point, w.last,
                                 result_kind, out_value, point_number, res_last);
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request.
    initial begin
        pop = 1'b0;
        rx_stall = 0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                pop <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (rx_stall > 0) begin
                pop <= 1'b0;
                rx_stall--;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                rx_stall = $urandom_range(1, 9) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        result_t none_r;
        int n;
        int r;
        logic [1:0] wk;
        none_r = '{default: '0};
        push = 1'b0;
        kind = KIND_PUSH;
        sample_value = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        no_idle = 1'b0;
        long_hold_req = 1'b0;
        mismatches = 0;
        results_seen = 0;
        pushes_done = 0;
        graphs_done = 0;
        peaks_done = 0;
        random_words = 0;
        shadow_wp = 0;
        shadow_fill = 0;
        reg_points = 7'd10;
        reg_window = 14'd4800;
        reg_offset = 14'd0;
        reg_sync = 2'd0;
        reg_peak = 13'd7200;

        // Directed table: reset defaults, extremes and every special case.
        plan_word(KIND_GRAPH, 16'sd0, 1'b1, RES_NOTREADY, 16'sd0);
        plan_word(KIND_PEAK, 16'sd0, 1'b1, RES_PEAK, 16'sd0);
        plan_word(KIND_NONE, 16'sd0);
        plan_cfg(CFG_PEAK, 1);
        plan_cfg(CFG_POINTS, 0);
        plan_cfg(CFG_WINDOW, 0);
        plan_word(KIND_PUSH, 16'sd0);
        plan_word(KIND_PUSH, 16'sd32767);
        plan_word(KIND_PUSH, -16'sd32768);
        plan_word(KIND_PEAK, 16'sd0, 1'b1, RES_PEAK, 16'sd32767);
        plan_word(KIND_GRAPH, 16'sd0);
        plan_cfg(CFG_POINTS, 127);
        plan_cfg(CFG_WINDOW, 5);
        plan_cfg(CFG_SYNC, SYNC_RISE);
        plan_cfg(CFG_OFFSET, 8192);
        plan_word(KIND_PUSH, 16'sd100);
        plan_word(KIND_PUSH, -16'sd5);
        plan_word(KIND_PUSH, -16'sd7);
        plan_word(KIND_PUSH, 16'sd3);
        plan_word(KIND_PUSH, 16'sd9);
        plan_word(KIND_PUSH, -16'sd1);
        plan_word(KIND_GRAPH, 16'sd0);
        plan_cfg(CFG_SYNC, SYNC_FALL);
        plan_cfg(CFG_OFFSET, 0);
        plan_cfg(CFG_WINDOW, 3);
        plan_cfg(CFG_POINTS, 64);
        plan_word(KIND_GRAPH, 16'sd0);
        plan_cfg(CFG_OFFSET, 2);
        plan_word(KIND_GRAPH, 16'sd0);
        plan_cfg(CFG_SYNC, 3);
        plan_cfg(CFG_WINDOW, 8192);
        plan_word(KIND_GRAPH, 16'sd0, 1'b1, RES_NOTREADY, 16'sd0);
        plan_cfg(CFG_WINDOW, 16383);
        plan_cfg(CFG_PEAK, 8191);
        plan_word(KIND_GRAPH, 16'sd0, 1'b1, RES_NOTREADY, 16'sd0);
        plan_word(KIND_PEAK, 16'sd0, 1'b1, RES_PEAK, 16'sd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                write_reg(plan[i].idx, 32'(plan[i].data));
            end else begin
                send_word(plan[i].wkind, plan[i].smp, plan[i].typed, plan[i].want);
                sender_gap();
            end
        end

        // Random phases: fresh settings, then mostly pushes with requests mixed in.
        for (int phase = 0; random_words < RANDOM_WORDS; phase++) begin
            drain();
            if (random_words > RANDOM_WORDS - 40) no_idle = 1'b1;
            write_reg(CFG_POINTS, ($urandom_range(0, 5) == 0) ? 127 : $urandom_range(0, 20));
            write_reg(CFG_WINDOW, $urandom_range(0, 40));
            write_reg(CFG_OFFSET, ($urandom_range(0, 7) == 0) ? 8192 : $urandom_range(0, 12));
            write_reg(CFG_SYNC, $urandom_range(0, 3));
            write_reg(CFG_PEAK, $urandom_range(1, 60));
            if (phase == 3) begin
                // Hold the receiver off while full-size graphs back up the input.
                write_reg(CFG_POINTS, 64);
                write_reg(CFG_WINDOW, 4);
                long_hold_req = 1'b1;
                for (int k = 0; k < 8; k++) begin
                    send_word(KIND_GRAPH, 16'sd0, 1'b0, none_r);
                    random_words++;
                end
            end
            n = $urandom_range(15, 30);
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 99);
                wk = (r < 70) ? KIND_PUSH : (r < 85) ? KIND_GRAPH : (r < 96) ? KIND_PEAK
                                                                              : KIND_NONE;
                send_word(wk, random_sample(), 1'b0, none_r);
                if (wk != KIND_NONE) random_words++;
                if (phase == 2 && k == n / 2) drain();
                else sender_gap();
            end
        end

        drain();
        $display("Covered %0d pushes, %0d graph and %0d peak requests; %0d result words checked.",
                 pushes_done, graphs_done, peaks_done, results_seen);
        $display("Settings swept included points 0..127, window 0..16383, all sync modes.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
